[design/wfc_pkg.sv]
// shared types and codes for the word frequency counter
// used by wfc_ctrl, wfc_datapath and the top level
`timescale 1ns / 1ps

package wfc_pkg;

    typedef enum logic [2:0] {
        RES_COUNTED  = 3'd0,
        RES_INSERTED = 3'd1,
        RES_SHORT    = 3'd2,
        RES_NUMERIC  = 3'd3,
        RES_FULL     = 3'd4,
        RES_READ     = 3'd5,
        RES_RANGE    = 3'd6
    } result_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LEN_WAIT,
        S_LEN_CMP,
        S_BYTE_WAIT,
        S_BYTE_CMP,
        S_UPDATE,
        S_INSERT,
        S_COPY_WAIT,
        S_COPY_WR,
        S_ADD,
        S_RD_BASE,
        S_RD_WAIT,
        S_RD_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_START,
        OP_NEXT_ENTRY,
        OP_START_BYTES,
        OP_NEXT_BYTE,
        OP_COPY_WR,
        OP_SHORT,
        OP_NUMERIC,
        OP_COUNT,
        OP_FULL,
        OP_INSERT,
        OP_RD_BASE,
        OP_RD_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic need_complete;
        logic too_short;
        logic numeric;
        logic used_zero;
        logic len_eq;
        logic byte_eq;
        logic last_byte;
        logic last_entry;
        logic table_full;
        logic out_free;
    } dp_status_t;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HIGH       = 8'h80;

endpackage

[design/wfc_ctrl.sv]
// sequencer for the word frequency counter
// drives wfc_datapath through ctrl_cmd_t, uses wfc_pkg
`timescale 1ns / 1ps

module wfc_ctrl
    import wfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (st.is_read) begin
                        state_next = S_RD_BASE;
                    end else if (st.need_complete) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (st.too_short || st.numeric) begin
                    if (st.out_free) state_next = S_IDLE;
                end else if (st.used_zero) begin
                    state_next = S_INSERT;
                end else begin
                    state_next = S_LEN_WAIT;
                end
            end
            S_LEN_WAIT:  state_next = S_LEN_CMP;
            S_LEN_CMP: begin
                if (st.len_eq) begin
                    state_next = S_BYTE_WAIT;
                end else begin
                    state_next = st.last_entry ? S_INSERT : S_LEN_WAIT;
                end
            end
            S_BYTE_WAIT: state_next = S_BYTE_CMP;
            S_BYTE_CMP: begin
                if (!st.byte_eq) begin
                    state_next = st.last_entry ? S_INSERT : S_LEN_WAIT;
                end else if (st.last_byte) begin
                    state_next = S_UPDATE;
                end else begin
                    state_next = S_BYTE_WAIT;
                end
            end
            S_UPDATE: begin
                if (st.out_free) state_next = S_IDLE;
            end
            S_INSERT: begin
                if (st.table_full) begin
                    if (st.out_free) state_next = S_IDLE;
                end else begin
                    state_next = S_COPY_WAIT;
                end
            end
            S_COPY_WAIT: state_next = S_COPY_WR;
            S_COPY_WR:   state_next = st.last_byte ? S_ADD : S_COPY_WAIT;
            S_ADD: begin
                if (st.out_free) state_next = S_IDLE;
            end
            S_RD_BASE:   state_next = S_RD_WAIT;
            S_RD_WAIT:   state_next = S_RD_DONE;
            S_RD_DONE: begin
                if (st.out_free) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_ACCEPT;
            end
            S_CHECK: begin
                if (st.too_short) begin
                    if (st.out_free) cmd.op = OP_SHORT;
                end else if (st.numeric) begin
                    if (st.out_free) cmd.op = OP_NUMERIC;
                end else begin
                    cmd.op = OP_START;
                end
            end
            S_LEN_CMP:  cmd.op = st.len_eq ? OP_START_BYTES : OP_NEXT_ENTRY;
            S_BYTE_CMP: begin
                if (!st.byte_eq) begin
                    cmd.op = OP_NEXT_ENTRY;
                end else if (!st.last_byte) begin
                    cmd.op = OP_NEXT_BYTE;
                end
            end
            S_UPDATE: begin
                if (st.out_free) cmd.op = OP_COUNT;
            end
            S_INSERT: begin
                if (st.table_full) begin
                    if (st.out_free) cmd.op = OP_FULL;
                end else begin
                    cmd.op = OP_START_BYTES;
                end
            end
            S_COPY_WR:  cmd.op = OP_COPY_WR;
            S_ADD: begin
                if (st.out_free) cmd.op = OP_INSERT;
            end
            S_RD_BASE:  cmd.op = OP_RD_BASE;
            S_RD_DONE: begin
                if (st.out_free) cmd.op = OP_RD_DONE;
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

[design/wfc_datapath.sv]
// pending word, word table memories, compare logic and result register
// driven by wfc_ctrl, uses wfc_pkg
`timescale 1ns / 1ps

module wfc_datapath
    import wfc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int WORD_BYTES    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  st,
    input  logic        in_req,
    input  logic [7:0]  in_byte,
    input  logic        in_eot,
    input  logic [9:0]  in_ridx,
    input  logic [5:0]  in_pos,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic [9:0]  out_idx,
    output logic [31:0] out_cnt,
    output logic [5:0]  out_len,
    output logic [7:0]  out_ch,
    output logic [10:0] out_used
);

    localparam int CAP = WORD_BYTES - 1;
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int UW  = $clog2(TABLE_ENTRIES + 1);
    localparam int LW  = $clog2(WORD_BYTES);
    localparam int KW  = $clog2(CAP);
    localparam int AW  = $clog2(TABLE_ENTRIES * CAP);

    logic [7:0]  pend_mem [CAP];
    logic [LW-1:0] len_mem [TABLE_ENTRIES];
    logic [31:0] cnt_mem [TABLE_ENTRIES];
    logic [7:0]  chr_mem [TABLE_ENTRIES * CAP];

    logic [LW-1:0] plen_reg;
    logic          digits_reg;
    logic [UW-1:0] used_reg;
    logic [IW-1:0] idx_reg;
    logic [AW-1:0] base_reg;
    logic [KW-1:0] k_reg;
    logic [9:0]    ridx_reg;
    logic [5:0]    pos_reg;

    logic [7:0]    pend_q;
    logic [7:0]    chr_q;
    logic [LW-1:0] len_q;
    logic [31:0]   cnt_q;

    logic          valid_reg;
    logic [2:0]    status_reg;
    logic [9:0]    oidx_reg;
    logic [31:0]   ocnt_reg;
    logic [5:0]    olen_reg;
    logic [7:0]    och_reg;
    logic [10:0]   oused_reg;

    logic          is_digit, is_word, appends;
    logic [LW-1:0] plen_after;
    logic [AW-1:0] chr_addr;
    logic [31:0]   cnt_inc;
    logic          pos_ok;

    assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign is_word  = is_digit || ((in_byte >= 8'h41) && (in_byte <= 8'h5A))
                   || ((in_byte >= 8'h61) && (in_byte <= 8'h7A))
                   || (in_byte == CH_UNDERSCORE) || (in_byte >= CH_HIGH);
    assign appends    = is_word && (plen_reg < LW'(CAP));
    assign plen_after = plen_reg + LW'(appends);
    assign chr_addr   = base_reg + AW'(k_reg);
    assign cnt_inc    = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
    assign pos_ok     = (pos_reg < 6'(len_q)) && (LW'(pos_reg) < LW'(CAP))
                     && (pos_reg < 6'(CAP) || CAP > 63);

    always_comb begin
        st.is_read       = in_req;
        st.need_complete = !in_req && ((!is_word && plen_reg != '0)
                                       || (in_eot && plen_after != '0));
        st.too_short     = plen_reg <= LW'(1);
        st.numeric       = digits_reg;
        st.used_zero     = used_reg == '0;
        st.len_eq        = len_q == plen_reg;
        st.byte_eq       = chr_q == pend_q;
        st.last_byte     = LW'(k_reg) == plen_reg - LW'(1);
        st.last_entry    = UW'(idx_reg) + UW'(1) == used_reg;
        st.table_full    = used_reg == UW'(TABLE_ENTRIES);
        st.out_free      = !valid_reg || out_ready;
    end

    // memories: registered reads
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_ACCEPT && !in_req && appends) begin
            pend_mem[plen_reg[KW-1:0]] <= in_byte;
        end
        pend_q <= pend_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_COPY_WR) begin
            chr_mem[chr_addr] <= pend_q;
        end
        chr_q <= chr_mem[chr_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_INSERT) begin
            len_mem[idx_reg] <= plen_reg;
        end
        len_q <= len_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_INSERT) begin
            cnt_mem[idx_reg] <= 32'd1;
        end else if (cmd.op == OP_COUNT) begin
            cnt_mem[idx_reg] <= cnt_inc;
        end
        cnt_q <= cnt_mem[idx_reg];
    end

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg   <= '0;
            digits_reg <= 1'b1;
            used_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_ACCEPT: begin
                    if (!in_req && appends) begin
                        plen_reg <= plen_reg + LW'(1);
                        if (!is_digit) digits_reg <= 1'b0;
                    end
                end
                OP_SHORT, OP_NUMERIC, OP_COUNT, OP_FULL: begin
                    plen_reg   <= '0;
                    digits_reg <= 1'b1;
                end
                OP_INSERT: begin
                    plen_reg   <= '0;
                    digits_reg <= 1'b1;
                    used_reg   <= used_reg + UW'(1);
                end
                default: ;
            endcase
        end
    end

    // search pointers, no reset needed
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                if (in_req) begin
                    ridx_reg <= in_ridx;
                    pos_reg  <= in_pos;
                    idx_reg  <= IW'(in_ridx);
                end
            end
            OP_START: begin
                idx_reg  <= '0;
                base_reg <= '0;
                k_reg    <= '0;
            end
            OP_NEXT_ENTRY: begin
                idx_reg  <= idx_reg + IW'(1);
                base_reg <= base_reg + AW'(CAP);
                k_reg    <= '0;
            end
            OP_START_BYTES: k_reg <= '0;
            OP_NEXT_BYTE, OP_COPY_WR: k_reg <= k_reg + KW'(1);
            OP_RD_BASE: begin
                base_reg <= AW'(idx_reg * CAP);
                k_reg    <= KW'(pos_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.op == OP_SHORT || cmd.op == OP_NUMERIC || cmd.op == OP_COUNT
                     || cmd.op == OP_FULL || cmd.op == OP_INSERT
                     || cmd.op == OP_RD_DONE) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_SHORT, OP_NUMERIC, OP_FULL: begin
                status_reg <= (cmd.op == OP_SHORT) ? RES_SHORT
                            : (cmd.op == OP_NUMERIC) ? RES_NUMERIC : RES_FULL;
                oidx_reg  <= '0;
                ocnt_reg  <= '0;
                olen_reg  <= 6'(plen_reg);
                och_reg   <= '0;
                oused_reg <= 11'(used_reg);
            end
            OP_COUNT: begin
                status_reg <= RES_COUNTED;
                oidx_reg   <= 10'(idx_reg);
                ocnt_reg   <= cnt_inc;
                olen_reg   <= 6'(plen_reg);
                och_reg    <= '0;
                oused_reg  <= 11'(used_reg);
            end
            OP_INSERT: begin
                status_reg <= RES_INSERTED;
                oidx_reg   <= 10'(idx_reg);
                ocnt_reg   <= 32'd1;
                olen_reg   <= 6'(plen_reg);
                och_reg    <= '0;
                oused_reg  <= 11'(used_reg + UW'(1));
            end
            OP_RD_DONE: begin
                oidx_reg  <= ridx_reg;
                oused_reg <= 11'(used_reg);
                if (UW'(ridx_reg) >= used_reg || 11'(ridx_reg) >= 11'(used_reg)) begin
                    status_reg <= RES_RANGE;
                    ocnt_reg   <= '0;
                    olen_reg   <= '0;
                    och_reg    <= '0;
                end else begin
                    status_reg <= RES_READ;
                    ocnt_reg   <= cnt_q;
                    olen_reg   <= 6'(len_q);
                    och_reg    <= pos_ok ? chr_q : 8'd0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_idx    = oidx_reg;
    assign out_cnt    = ocnt_reg;
    assign out_len    = olen_reg;
    assign out_ch     = och_reg;
    assign out_used   = oused_reg;

endmodule

[design/word_frequency_counter_core.sv]
// word frequency counter: counts distinct words of a byte stream in a table
// instantiates wfc_ctrl and wfc_datapath, uses wfc_pkg
//
// input beats: s_tuser = 0 carries one text byte, s_tlast flushes the
// pending word after the byte; s_tuser = 1 asks for one stored entry
// (entry index and byte position in s_tdata).
// result beats carry the status code in m_tuser and index, count, length,
// byte and number of used entries in m_tdata; a beat gives zero or one
// result.
// a byte that only extends the pending word is taken in the idle state; a
// completed word is searched entry by entry in the table memories: each
// stored length is read and compared, then each byte of an equal-length
// entry; a match is counted, else the word is copied in byte by byte. a
// read forms the entry base, then reads the memories. all of it is set by
// the single port of each table memory. at reset the table is empty and the
// pending word cleared; the table memories need no clearing pass. a stalled
// receiver holds the result register; bytes that give no result are still
// taken, and the sequencer waits only where it has a new result to place.
`timescale 1ns / 1ps

module word_frequency_counter_core
    import wfc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int WORD_BYTES    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // text_byte, read_entry, char_position
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // entry_index, word_count_value, word_length,
                                   // char_value, entries_used, zero fill
    output logic [2:0]  m_tuser    // status
);

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic [2:0]  o_status;
    logic [9:0]  o_idx;
    logic [31:0] o_cnt;
    logic [5:0]  o_len;
    logic [7:0]  o_ch;
    logic [10:0] o_used;

    wfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    wfc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WORD_BYTES    (WORD_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .in_req     (s_tuser),
        .in_byte    (s_tdata[7:0]),
        .in_eot     (s_tlast),
        .in_ridx    (s_tdata[17:8]),
        .in_pos     (s_tdata[23:18]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (o_status),
        .out_idx    (o_idx),
        .out_cnt    (o_cnt),
        .out_len    (o_len),
        .out_ch     (o_ch),
        .out_used   (o_used)
    );

    assign m_tuser = o_status;
    assign m_tdata = {5'd0, o_used, o_ch, o_len, o_cnt, o_idx};

endmodule

[design/wfc_checker.sv]
// port-level checks for word_frequency_counter_core
// bound to the top level below, uses wfc_pkg
`timescale 1ns / 1ps

module wfc_checker
    import wfc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RES_READ |-> {1'b0, m_tdata[9:0]} < m_tdata[66:56])
        else $error("read reply for an unused entry");

    a_insert_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RES_INSERTED |-> m_tdata[41:10] == 32'd1
            && m_tdata[66:56] != 11'd0)
        else $error("inserted word without count one");

    a_counted_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RES_COUNTED |-> m_tdata[41:10] > 32'd1)
        else $error("counted word with count below two");

endmodule

bind word_frequency_counter_core wfc_checker u_wfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/tb_word_frequency_counter_core.sv]
// testbench for word_frequency_counter_core: directed table, random text, table fill
// depends on wfc_pkg and the design files; predicts every result beat in-house
`timescale 1ns / 1ps

module tb_word_frequency_counter_core;
    import wfc_pkg::*;

    localparam int ENTRIES   = 1024;
    localparam int CAP       = 63;
    localparam int N_RANDOM  = 1750;
    localparam int LIMIT     = 20000000;

    typedef struct packed {
        logic       req;
        logic [7:0] ch;
        logic       eot;
        logic [9:0] ridx;
        logic [5:0] pos;
    } text_req_t;

    typedef struct packed {
        result_code_t st;
        logic [9:0]   idx;
        logic [31:0]  cnt;
        logic [5:0]   len;
        logic [7:0]   chv;
        logic [10:0]  used;
    } word_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    word_frequency_counter_core dut (.*);

    always #6 aclk = ~aclk;

    // model state of the word table
    logic [7:0]  tab_chars [ENTRIES][CAP];
    logic [5:0]  tab_len [ENTRIES];
    logic [31:0] tab_cnt [ENTRIES];
    int          tab_used = 0;
    logic [7:0]  pend_word [CAP];
    int          pend_len = 0;
    bit          pend_digits = 1;

    word_result_t pending_results[$];
    int errors = 0;
    int n_results = 0;
    int n_beats = 0;
    int status_seen [8];
    int cycles = 0;

    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               c == CH_UNDERSCORE || c >= CH_HIGH;
    endfunction

    function automatic word_result_t close_word();
        word_result_t r;
        int len;
        bit same;
        len = pend_len;
        pend_len = 0;
        r = '0;
        r.len = len[5:0];
        if (len <= 1) begin
            pend_digits = 1;
            r.st = RES_SHORT;
        end else if (pend_digits) begin
            r.st = RES_NUMERIC;
        end else begin
            pend_digits = 1;
            for (int i = 0; i < tab_used; i++) begin
                if (tab_len[i] == len) begin
                    same = 1;
                    for (int j = 0; j < len; j++)
                        if (tab_chars[i][j] != pend_word[j]) same = 0;
                    if (same) begin
                        if (tab_cnt[i] != 32'hFFFF_FFFF) tab_cnt[i]++;
                        r.st  = RES_COUNTED;
                        r.idx = i[9:0];
                        r.cnt = tab_cnt[i];
                        r.used = tab_used[10:0];
                        return r;
                    end
                end
            end
            if (tab_used < ENTRIES) begin
                for (int j = 0; j < len; j++) tab_chars[tab_used][j] = pend_word[j];
                tab_len[tab_used] = len[5:0];
                tab_cnt[tab_used] = 1;
                r.st  = RES_INSERTED;
                r.idx = tab_used[9:0];
                r.cnt = 1;
                tab_used++;
            end else begin
                r.st = RES_FULL;
            end
        end
        r.used = tab_used[10:0];
        return r;
    endfunction

    // returns 1 when the beat causes a result
    function automatic bit count_table_step(text_req_t t, output word_result_t r);
        r = '0;
        if (t.req) begin
            r.idx  = t.ridx;
            r.used = tab_used[10:0];
            if (t.ridx >= tab_used) begin
                r.st = RES_RANGE;
            end else begin
                r.st  = RES_READ;
                r.cnt = tab_cnt[t.ridx];
                r.len = tab_len[t.ridx];
                if (t.pos < tab_len[t.ridx]) r.chv = tab_chars[t.ridx][t.pos];
            end
            return 1;
        end
        if (is_word(t.ch)) begin
            if (pend_len < CAP) begin
                pend_word[pend_len] = t.ch;
                pend_len++;
                if (!is_digit(t.ch)) pend_digits = 0;
            end
        end else if (pend_len > 0) begin
            r = close_word();
            return 1;
        end
        if (t.eot && pend_len > 0) begin
            r = close_word();
            return 1;
        end
        return 0;
    endfunction

    // sender burst shaping
    int burst_left = 0;
    bit no_gaps = 0;

    task automatic send(text_req_t t, bit typed = 0, word_result_t typed_res = '0);
        word_result_t r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            no_gaps = ($urandom_range(0, 3) == 0);
            gap = no_gaps ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= t.req;
        s_tlast  <= t.eot;
        s_tdata  <= {t.pos, t.ridx, t.ch};
        do @(posedge aclk); while (!s_tready);
        n_beats++;
        if (count_table_step(t, r)) pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic text_req_t noise_fields();
        text_req_t t;
        t.req  = 1'b0;
        t.ch   = 8'($urandom_range(0, 255));
        t.eot  = 1'b0;
        t.ridx = 10'($urandom_range(0, 1023));
        t.pos  = 6'($urandom_range(0, 63));
        return t;
    endfunction

    function automatic logic [7:0] rand_word_byte(bit digits_only);
        int k;
        if (digits_only) return 8'(8'h30 + $urandom_range(0, 9));
        k = $urandom_range(0, 5);
        case (k)
            0: return 8'(8'h30 + $urandom_range(0, 9));
            1: return 8'(8'h41 + $urandom_range(0, 25));
            2: return CH_UNDERSCORE;
            3: return 8'($urandom_range(128, 255));
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rand_separator();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_word(c));
        return c;
    endfunction

    // receiver stall pattern, switching between four random modes
    int stall_mode = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 200 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 9) == 0);
            default: m_tready <= ((cycles / 7) % 2 == 0);
        endcase
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        word_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.st   = result_code_t'(m_tuser);
            got.idx  = m_tdata[9:0];
            got.cnt  = m_tdata[41:10];
            got.len  = m_tdata[47:42];
            got.chv  = m_tdata[55:48];
            got.used = m_tdata[66:56];
            n_results++;
            status_seen[m_tuser]++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat, status %0d", m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[71:67] !== 5'd0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp st=%0d idx=%0d cnt=%0d len=%0d ch=%h used=%0d",
                                 want.st, want.idx, want.cnt, want.len, want.chv, want.used);
                        $display("          got st=%0d idx=%0d cnt=%0d len=%0d ch=%h used=%0d",
                                 got.st, got.idx, got.cnt, got.len, got.chv, got.used);
                    end
                end
            end
        end
    end

    typedef struct {
        text_req_t    t;
        bit           typed;
        word_result_t res;
    } dir_row_t;

    dir_row_t dir_rows[$];
    logic [7:0] vocab [24][70];
    int vocab_len [24];

    function automatic void row(bit req, logic [7:0] ch, bit eot, int ridx, int pos,
                                bit typed = 0, result_code_t st = RES_COUNTED, int idx = 0,
                                int cnt = 0, int len = 0, int chv = 0, int used = 0);
        dir_row_t d;
        d.t = '{req, ch, eot, ridx[9:0], pos[5:0]};
        d.typed = typed;
        d.res = '{st, idx[9:0], cnt[31:0], len[5:0], chv[7:0], used[10:0]};
        dir_rows.push_back(d);
    endfunction

    initial begin
        text_req_t t;
        int k, w, lo, hi;
        logic [7:0] c1, c2;
        word_result_t r;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        row(1, 8'h00, 0, 0, 0, 1, RES_RANGE, 0, 0, 0, 0, 0);       // empty table read
        row(0, 8'h61, 0, 1023, 63);
        row(0, 8'h62, 0, 0, 0);
        row(0, 8'h20, 0, 0, 0, 1, RES_INSERTED, 0, 1, 2, 0, 1);
        row(0, 8'h61, 0, 0, 0);
        row(0, 8'h62, 1, 0, 0, 1, RES_COUNTED, 0, 2, 2, 0, 1);     // flush on last byte
        row(0, 8'h78, 0, 0, 0);
        row(0, 8'h00, 0, 0, 0, 1, RES_SHORT, 0, 0, 1, 0, 1);
        row(0, 8'h31, 0, 0, 0);
        row(0, 8'h39, 0, 0, 0);
        row(0, 8'h2C, 1, 0, 0, 1, RES_NUMERIC, 0, 0, 2, 0, 1);     // separator and flush
        row(0, 8'hFF, 0, 0, 0);
        row(1, 8'h20, 1, 0, 1, 1, RES_READ, 0, 2, 2, 8'h62, 1);    // read leaves word alone
        row(0, CH_UNDERSCORE, 0, 0, 0);
        row(0, CH_HIGH, 0, 0, 0);
        row(0, 8'h7F, 0, 0, 0);
        row(1, 8'h00, 0, 1, 63);
        row(1, 8'hFF, 0, 0, 63, 1, RES_READ, 0, 2, 2, 0, 2);       // past the word
        row(1, 8'h00, 0, 1023, 0, 1, RES_RANGE, 1023, 0, 0, 0, 2);
        row(0, 8'h20, 1, 0, 0);                                    // no pending word
        row(0, 8'h5A, 0, 0, 0);
        row(0, 8'h5A, 1, 0, 0);
        foreach (dir_rows[i]) send(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].res);

        // vocabulary: mostly short words, some numeric, some overlong
        for (int v = 0; v < 24; v++) begin
            k = $urandom_range(0, 11);
            vocab_len[v] = (k == 0) ? $urandom_range(62, 70) :
                           (k == 1) ? 1 : $urandom_range(2, 9);
            for (int j = 0; j < vocab_len[v]; j++) vocab[v][j] = rand_word_byte(k == 2);
        end

        // random part
        while (n_beats < N_RANDOM + dir_rows.size()) begin
            if (n_beats > 900 && n_beats < 910) drain();
            k = $urandom_range(0, 9);
            if (k < 8) begin
                w = $urandom_range(0, 23);
                for (int j = 0; j < vocab_len[w]; j++) begin
                    t = noise_fields();
                    t.ch = vocab[w][j];
                    t.eot = (j == vocab_len[w] - 1) && ($urandom_range(0, 2) == 0);
                    send(t);
                end
                if (!t.eot) begin
                    t = noise_fields();
                    t.ch = rand_separator();
                    t.eot = ($urandom_range(0, 3) == 0);
                    send(t);
                end
            end else if (k == 8) begin
                t = noise_fields();
                t.req = 1'b1;
                t.eot = 1'($urandom_range(0, 1));
                if (tab_used > 0 && $urandom_range(0, 3) != 0)
                    t.ridx = 10'($urandom_range(0, tab_used - 1));
                send(t);
            end else begin
                t = noise_fields();
                t.eot = ($urandom_range(0, 7) == 0);
                send(t);
            end
        end

        // fill the table with distinct two-letter words, then overflow it
        drain();
        lo = 0;
        while (tab_used < ENTRIES + 4) begin
            c1 = 8'((lo / 52 < 26) ? 8'h41 + lo / 52 : 8'h61 + lo / 52 - 26);
            c2 = 8'((lo % 52 < 26) ? 8'h41 + lo % 52 : 8'h61 + lo % 52 - 26);
            lo++;
            if (lo >= 52 * 52) break;
            t = noise_fields();
            t.ch = c1;
            send(t);
            t = noise_fields();
            t.ch = c2;
            t.eot = 1'b1;
            send(t);
            if (tab_used == ENTRIES) begin
                hi++;
                if (hi > 4) break;
            end
        end
        for (int j = 0; j < 6; j++) begin
            t = noise_fields();
            t.req = 1'b1;
            t.ridx = 10'(1023 - j);
            send(t);
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("%0d input beats, %0d result beats, table entries used %0d", n_beats,
                 n_results, tab_used);
        $display("status mix: counted %0d inserted %0d short %0d numeric %0d full %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        $display("            read %0d range %0d", status_seen[5], status_seen[6]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
